### hdl/dlw_pkg.sv
// Shared types and constants for the deduplicating LIFO worklist.
package dlw_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef struct packed {
    handle_t src_object;
    handle_t src_local;
    handle_t src_global;
    handle_t dst_object;
  } tuple_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_POPPED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ADD = 1'b0,
    MODE_POP = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_EXEC
  } fsm_t;

endpackage

### hdl/dedup_lifo_worklist_top.sv
// Top level of the deduplicating LIFO worklist: request latch, cell chain, control.
//
//  channel  | signals                                           | handshake
//  ---------+---------------------------------------------------+---------------------------
//  command  | mode, src_object, src_local, src_global, dst_object | beat on start & !busy
//  result   | status, out_src_object .. out_dst_object, now_empty | beat on done, one cycle
//
//  Each beat runs through latch, parallel compare in every cell, then decide and shift.
//  The result strobe rises the cycle after the shift; busy is already low then.
//  The compare stage is set by the registered hit flag of each cell in the chain.
//  Reset (rst, synchronous) empties the list at once; stored tuples are not cleared.
//  The receiver cannot stall: a result is shown for one cycle only.
module dedup_lifo_worklist_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] src_object,
  input  logic [31:0] src_local,
  input  logic [31:0] src_global,
  input  logic [31:0] dst_object,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] out_src_object,
  output logic [31:0] out_src_local,
  output logic [31:0] out_src_global,
  output logic [31:0] out_dst_object,
  output logic        now_empty
);

  dlw_pkg::fsm_t    state, state_next;
  dlw_pkg::count_t  count, count_next;
  dlw_pkg::tuple_t  key;
  dlw_pkg::mode_t   req_mode;
  dlw_pkg::shift_t  ctrl;
  dlw_pkg::status_t res_status;
  dlw_pkg::tuple_t  res_tuple;
  dlw_pkg::tuple_t  tuples [dlw_pkg::CAPACITY];
  logic [dlw_pkg::CAPACITY-1:0] hits;
  logic [dlw_pkg::CAPACITY-1:0] occupied;
  logic accept, hit_any, full;

  assign accept = start && !busy;
  assign busy   = (state != dlw_pkg::FSM_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= '{src_object, src_local, src_global, dst_object};
      req_mode <= dlw_pkg::mode_t'(mode);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dlw_pkg::FSM_IDLE: if (start) state_next = dlw_pkg::FSM_CMP;
      dlw_pkg::FSM_CMP:  state_next = dlw_pkg::FSM_EXEC;
      dlw_pkg::FSM_EXEC: state_next = dlw_pkg::FSM_IDLE;
      default:           state_next = dlw_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < dlw_pkg::CAPACITY; i++) begin
      occupied[i] = (dlw_pkg::count_t'(i) < count);
    end
  end

  assign hit_any = |(hits & occupied);
  assign full    = (count == dlw_pkg::count_t'(dlw_pkg::CAPACITY));

  always_comb begin
    ctrl       = '0;
    count_next = count;
    res_status = dlw_pkg::ST_EMPTY;
    res_tuple  = '0;
    if (state == dlw_pkg::FSM_EXEC) begin
      case (req_mode)
        dlw_pkg::MODE_ADD: begin
          if (hit_any) begin
            res_status = dlw_pkg::ST_PRESENT;
          end else if (full) begin
            res_status = dlw_pkg::ST_FULL;
          end else begin
            ctrl.push  = 1'b1;
            count_next = count + 1'b1;
            res_status = dlw_pkg::ST_INSERTED;
          end
        end
        dlw_pkg::MODE_POP: begin
          if (count == '0) begin
            res_status = dlw_pkg::ST_EMPTY;
          end else begin
            ctrl.pop   = 1'b1;
            count_next = count - 1'b1;
            res_status = dlw_pkg::ST_POPPED;
            res_tuple  = tuples[0];
          end
        end
        default: res_status = dlw_pkg::ST_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlw_pkg::FSM_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == dlw_pkg::FSM_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == dlw_pkg::FSM_EXEC) begin
      status         <= res_status;
      out_src_object <= res_tuple.src_object;
      out_src_local  <= res_tuple.src_local;
      out_src_global <= res_tuple.src_global;
      out_dst_object <= res_tuple.dst_object;
      now_empty      <= (count_next == '0);
    end
  end

  for (genvar g = 0; g < dlw_pkg::CAPACITY; g++) begin : g_cell
    dlw_pkg::tuple_t up_t, dn_t;
    if (g == 0) begin : g_head
      assign up_t = key;
    end else begin : g_body
      assign up_t = tuples[g-1];
    end
    if (g == dlw_pkg::CAPACITY - 1) begin : g_tail
      assign dn_t = '0;
    end else begin : g_link
      assign dn_t = tuples[g+1];
    end
    dlw_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .key     (key),
      .from_up (up_t),
      .from_dn (dn_t),
      .tuple   (tuples[g]),
      .hit     (hits[g])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dlw_pkg::count_t'(dlw_pkg::CAPACITY))
    else $error("fill count beyond capacity");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    state == dlw_pkg::FSM_EXEC |=> done)
    else $error("decision without result strobe");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (now_empty == (count == '0)))
    else $error("empty flag disagrees with fill count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == dlw_pkg::ST_INSERTED) |-> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == dlw_pkg::FSM_CMP)
    else $error("accepted beat not compared");

endmodule

### hdl/dlw_cell.sv
// One stack slot: holds a tuple, shifts with its neighbours, compares against the key.
module dlw_cell (
  input  logic            clk,
  input  dlw_pkg::shift_t ctrl,
  input  dlw_pkg::tuple_t key,
  input  dlw_pkg::tuple_t from_up,
  input  dlw_pkg::tuple_t from_dn,
  output dlw_pkg::tuple_t tuple,
  output logic            hit
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      tuple <= from_up;
    end else if (ctrl.pop) begin
      tuple <= from_dn;
    end
    hit <= (tuple == key);
  end

endmodule
